// ===== src/mpbp_pkg.sv =====
package mpbp_pkg;

   localparam int PIXEL_BITS = 32;
   localparam int WORD_BITS = 32;
   localparam int BIT_COUNT_BITS = 6;
   localparam int CSR_INDEX_BITS = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_BITS-1:0] PIXEL_MASK =
      WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_USED_BIT_MASK = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_BIT_MASK = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_SIZE_CODE = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_ONES = 8'd3;

   localparam logic [WORD_BITS-1:0] USED_RESET = 32'hffffffff;
   localparam logic [WORD_BITS-1:0] FILL_RESET = 32'h000000ff;

   typedef struct packed {
      logic [WORD_BITS-1:0] pixel_word;
      logic [WORD_BITS-1:0] used_bits;
      logic                 last_pixel;
   } item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]      fill_mask;
      logic [BIT_COUNT_BITS-1:0] fill_count;
      logic                      default_ones;
      logic                      write;
   } cfg_type;

   function automatic logic [WORD_BITS-1:0] width_mask(input logic [1:0] code);
      return 32'hffffffff >> {~code, 3'b000};
   endfunction

   // Isolates the most significant set bit as a one-hot word.
   function automatic logic [WORD_BITS-1:0] top_bit(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] s;
      s = x;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      return s & ~(s >> 1);
   endfunction

   // Counts the set bits with a tree of partial sums.
   function automatic logic [BIT_COUNT_BITS-1:0] ones_count(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] s;
      s = x - ((x >> 1) & 32'h55555555);
      s = (s & 32'h33333333) + ((s >> 2) & 32'h33333333);
      s = (s + (s >> 4)) & 32'h0f0f0f0f;
      s = s + (s >> 8);
      s = s + (s >> 16);
      return s[BIT_COUNT_BITS-1:0];
   endfunction

endpackage

// ===== src/masked_pixel_bit_packer.sv =====
// Pixels arrive on the req_ stream and are queued two deep; the packing engine then takes one
// selected pixel bit per cycle while it is not stalled. For each pixel it first loads the
// pixel, then places one set bit of the used mask at a time, and when the last pixel ends it
// flushes a partly filled block; a pixel with an empty used mask is still loaded. Each
// finished block waits in an output register, so the engine runs on while a transfer on rsp_ is
// pending and stalls only when a second block is ready before the first is taken.
// Configuration writes are accepted in every cycle, should be made only while the block is
// idle, and abandon any block being built.
module masked_pixel_bit_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpbp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mpbp_pkg::WORD_BITS-1:0]      csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mpbp_pkg::WORD_BITS-1:0]      req_tdata,  // pixel_word
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mpbp_pkg::WORD_BITS-1:0]      rsp_tdata,  // block_word
   output logic                                rsp_tlast,
   output logic [0:0]                          rsp_tuser   // end_of_stream
);

   mpbp_pkg::item_type push_item;
   mpbp_pkg::item_type queue_head;
   mpbp_pkg::cfg_type  cfg;
   logic               push_valid;
   logic               queue_full;
   logic               queue_empty;
   logic               queue_pop;

   mpbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item),
      .cfg        (cfg)
   );

   mpbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   mpbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== src/mpbp_front.sv =====
module mpbp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mpbp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mpbp_pkg::WORD_BITS-1:0]        csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mpbp_pkg::WORD_BITS-1:0]        req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  queue_full,
   output logic                                  push_valid,
   output mpbp_pkg::item_type                    push_item,
   output mpbp_pkg::cfg_type                     cfg
);

   logic [mpbp_pkg::WORD_BITS-1:0] used_ff, used_in;
   logic [mpbp_pkg::WORD_BITS-1:0] fill_ff, fill_in;
   logic [1:0]                     size_ff, size_in;
   logic                           dflt_ff, dflt_in;
   logic                           csr_write;
   logic                           csr_hit;
   logic [mpbp_pkg::WORD_BITS-1:0] fill_eff;
   logic                           keep;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      used_in = used_ff;
      fill_in = fill_ff;
      size_in = size_ff;
      dflt_in = dflt_ff;
      csr_hit = 1'b0;
      if (csr_write) begin
         case (csr_index)
            mpbp_pkg::CSR_USED_BIT_MASK: begin
               used_in = csr_data;
               csr_hit = 1'b1;
            end
            mpbp_pkg::CSR_FILL_BIT_MASK: begin
               fill_in = csr_data;
               csr_hit = 1'b1;
            end
            mpbp_pkg::CSR_BLOCK_SIZE_CODE: begin
               size_in = csr_data[1:0];
               csr_hit = 1'b1;
            end
            mpbp_pkg::CSR_DEFAULT_ONES: begin
               dflt_in = csr_data[0];
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= mpbp_pkg::USED_RESET;
         fill_ff <= mpbp_pkg::FILL_RESET;
         size_ff <= 2'd0;
         dflt_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
         size_ff <= size_in;
         dflt_ff <= dflt_in;
      end
   end

   assign fill_eff = fill_ff & mpbp_pkg::width_mask(size_ff);
   assign keep = |fill_eff;

   // When the block has no fill position, every pixel is reduced to an empty item.
   assign req_tready = ~queue_full;
   assign push_valid = req_tvalid & req_tready;
   assign push_item.pixel_word = req_tdata;
   assign push_item.used_bits = keep ? (used_ff & mpbp_pkg::PIXEL_MASK) : '0;
   assign push_item.last_pixel = keep & req_tlast;

   assign cfg.fill_mask = fill_eff;
   assign cfg.fill_count = mpbp_pkg::ones_count(fill_eff);
   assign cfg.default_ones = dflt_ff;
   assign cfg.write = csr_hit;

endmodule

// ===== src/mpbp_queue.sv =====
module mpbp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mpbp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output mpbp_pkg::item_type head
);

   mpbp_pkg::item_type                         entry_ff [mpbp_pkg::QUEUE_DEPTH];
   logic [mpbp_pkg::QUEUE_PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mpbp_pkg::QUEUE_PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mpbp_pkg::QUEUE_COUNT_BITS-1:0]      count_ff, count_in;
   logic                                       do_push;
   logic                                       do_pop;

   assign full = count_ff == mpbp_pkg::QUEUE_COUNT_BITS'(mpbp_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push_valid & ~full;
   assign do_pop = pop & ~empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mpbp_pkg::QUEUE_PTR_BITS'(mpbp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mpbp_pkg::QUEUE_PTR_BITS'(mpbp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/mpbp_back.sv =====
module mpbp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  mpbp_pkg::cfg_type              cfg,
   input  logic                           queue_empty,
   input  mpbp_pkg::item_type             queue_head,
   output logic                           queue_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mpbp_pkg::WORD_BITS-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic [0:0]                     rsp_tuser
);

   logic                           active_ff, active_in;
   logic [mpbp_pkg::WORD_BITS-1:0] pixel_ff, pixel_in;
   logic [mpbp_pkg::WORD_BITS-1:0] rem_ff, rem_in;
   logic [mpbp_pkg::BIT_COUNT_BITS-1:0] bits_left_ff, bits_left_in;
   logic                           last_ff, last_in;
   logic                           started_ff, started_in;
   logic [mpbp_pkg::WORD_BITS-1:0] fill_left_ff, fill_left_in;
   logic [mpbp_pkg::WORD_BITS-1:0] partial_ff, partial_in;
   logic                           out_valid_ff, out_valid_in;
   logic [mpbp_pkg::WORD_BITS-1:0] out_data_ff, out_data_in;
   logic                           out_run_ff, out_run_in;
   logic                           out_stream_ff, out_stream_in;

   logic [mpbp_pkg::WORD_BITS-1:0] avail;
   logic [mpbp_pkg::WORD_BITS-1:0] fill_hot;
   logic [mpbp_pkg::WORD_BITS-1:0] used_hot;
   logic [mpbp_pkg::WORD_BITS-1:0] base;
   logic [mpbp_pkg::WORD_BITS-1:0] written;
   logic [mpbp_pkg::WORD_BITS-1:0] left_next;
   logic [mpbp_pkg::WORD_BITS-1:0] rem_next;
   logic [mpbp_pkg::BIT_COUNT_BITS-1:0] bits_after;
   logic                           more_blocks;
   logic                           bit_value;
   logic                           out_free;
   logic                           out_load;

   assign avail = started_ff ? fill_left_ff : cfg.fill_mask;
   assign fill_hot = mpbp_pkg::top_bit(avail);
   assign used_hot = mpbp_pkg::top_bit(rem_ff);
   assign bit_value = |(pixel_ff & used_hot);
   assign base = started_ff ? partial_ff : {mpbp_pkg::WORD_BITS{cfg.default_ones}};
   assign written = bit_value ? (base | fill_hot) : (base & ~fill_hot);
   assign left_next = avail & ~fill_hot;
   assign rem_next = rem_ff & ~used_hot;
   assign out_free = ~out_valid_ff | rsp_tready;
   assign queue_pop = ~active_ff & ~queue_empty;

   // After a block goes out, the pixel still yields another one if its remaining bits fill a
   // whole block or if it is the last pixel and a partial block will be flushed.
   assign bits_after = bits_left_ff - 1'b1;
   assign more_blocks = (bits_after >= cfg.fill_count) | (last_ff & (bits_after != '0));

   always_comb begin
      active_in = active_ff;
      pixel_in = pixel_ff;
      rem_in = rem_ff;
      bits_left_in = bits_left_ff;
      last_in = last_ff;
      started_in = started_ff;
      fill_left_in = fill_left_ff;
      partial_in = partial_ff;
      out_load = 1'b0;
      out_data_in = out_data_ff;
      out_run_in = out_run_ff;
      out_stream_in = out_stream_ff;

      if (!active_ff) begin
         if (!queue_empty) begin
            active_in = 1'b1;
            pixel_in = queue_head.pixel_word;
            rem_in = queue_head.used_bits;
            bits_left_in = mpbp_pkg::ones_count(queue_head.used_bits);
            last_in = queue_head.last_pixel;
         end
      end else if (rem_ff != '0) begin
         if (left_next == '0) begin
            // The lowest fill position is written, so the block goes out.
            if (out_free) begin
               out_load = 1'b1;
               out_data_in = written;
               out_run_in = ~more_blocks;
               out_stream_in = ~more_blocks & last_ff;
               started_in = 1'b0;
               rem_in = rem_next;
               bits_left_in = bits_after;
               active_in = rem_next != '0;
            end
         end else begin
            partial_in = written;
            fill_left_in = left_next;
            started_in = 1'b1;
            rem_in = rem_next;
            bits_left_in = bits_after;
            active_in = (rem_next != '0) | last_ff;
         end
      end else if (last_ff && started_ff) begin
         if (out_free) begin
            out_load = 1'b1;
            out_data_in = partial_ff;
            out_run_in = 1'b1;
            out_stream_in = 1'b1;
            started_in = 1'b0;
            active_in = 1'b0;
         end
      end else begin
         active_in = 1'b0;
      end

      if (cfg.write) begin
         started_in = 1'b0;
      end

      out_valid_in = out_load | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         started_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         started_ff <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      rem_ff <= rem_in;
      bits_left_ff <= bits_left_in;
      last_ff <= last_in;
      fill_left_ff <= fill_left_in;
      partial_ff <= partial_in;
      if (out_load) begin
         out_data_ff <= out_data_in;
         out_run_ff <= out_run_in;
         out_stream_ff <= out_stream_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_run_ff;
   assign rsp_tuser = out_stream_ff;

endmodule

// ===== src/mpbp_checker.sv =====
module mpbp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mpbp_pkg::WORD_BITS-1:0]      rsp_tdata,
   input logic                                rsp_tlast,
   input logic [0:0]                          rsp_tuser
);

   // A block that closes the stream is always the last one of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("end of stream without end of run");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind masked_pixel_bit_packer mpbp_checker u_mpbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
